// ===== src/bqd_pkg.sv =====
// Package for the biquad IIR filter: shared constants, register map,
// sequencer states and the multiply-accumulate control struct.
// No dependencies; every other file of the block uses it.
package bqd_pkg;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;

  // Delay words are fixed at 32 bits, same LSB as a sample
  localparam int STATE_BITS = 32;
  // Width of the rounded accumulator output (integer part plus headroom)
  localparam int Q_BITS     = STATE_BITS + 7;
  localparam int THR_BITS   = 8;
  localparam int NUM_COEF   = 5;
  localparam int REG_IDX_BITS = 3;

  // Register map, in address order
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_COEF_FF0  = 3'd0,
    REG_COEF_FF1  = 3'd1,
    REG_COEF_FF2  = 3'd2,
    REG_COEF_FB1  = 3'd3,
    REG_COEF_FB2  = 3'd4,
    REG_FLUSH_THR = 3'd5
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB1,
    ST_FB2,
    ST_FBW,
    ST_FBSAT,
    ST_FF0,
    ST_FF1,
    ST_FF2,
    ST_FFW,
    ST_EMIT
  } bqd_state_t;

  // Control word for the shared multiply-accumulate unit
  typedef struct packed {
    logic load;    // restart the accumulator with the rounding bias
    logic load_x;  // also preload the input sample, scaled to the product LSB
    logic mul_en;  // launch a product this cycle
    logic sub;     // subtract the product when it is accumulated
  } mac_ctl_t;

endpackage

// ===== src/bqd_ifs.sv =====
// Handshake channel interfaces of the biquad filter: input samples and
// filtered results, each with valid/ready. Depends on bqd_pkg.
interface bqd_in_if #(
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_end;
  logic                          clear;

  modport source (output valid, channel, sample_in, block_end, clear, input ready);
  modport sink   (input valid, channel, sample_in, block_end, clear, output ready);
endinterface

interface bqd_out_if #(
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          channel_out;
  logic                          block_end_out;
  logic                          saturated;

  modport source (output valid, sample_out, channel_out, block_end_out, saturated,
                  input ready);
  modport sink   (input valid, sample_out, channel_out, block_end_out, saturated,
                  output ready);
endinterface

// ===== src/bqd_cfg.sv =====
// APB-style configuration registers of the biquad filter: five Q4.28
// coefficients and the flush threshold. Depends on bqd_pkg.
module bqd_cfg #(
  parameter int COEF_BITS = bqd_pkg::COEF_BITS_DEF,
  parameter int DATA_W    = 32,
  parameter int ADDR_W    = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_W-1:0]           paddr,
  input  logic [DATA_W-1:0]           pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready,
  output logic signed [COEF_BITS-1:0] coef_o [bqd_pkg::NUM_COEF],
  output logic [bqd_pkg::THR_BITS-1:0] thr_o
);
  import bqd_pkg::*;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << (COEF_BITS - 4);

  logic signed [COEF_BITS-1:0] coef_r [NUM_COEF];
  logic [THR_BITS-1:0]         thr_r;
  logic [REG_IDX_BITS-1:0]     reg_idx;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_BITS];
  assign wr_en   = psel && penable && pwrite;

  // Write registers on the access phase; unmapped addresses are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_COEF_FF0] <= COEF_ONE;
      coef_r[REG_COEF_FF1] <= '0;
      coef_r[REG_COEF_FF2] <= '0;
      coef_r[REG_COEF_FB1] <= '0;
      coef_r[REG_COEF_FB2] <= '0;
      thr_r                <= THR_BITS'(1);
    end else if (wr_en) begin
      case (reg_idx_t'(reg_idx))
        REG_COEF_FF0, REG_COEF_FF1, REG_COEF_FF2, REG_COEF_FB1, REG_COEF_FB2: begin
          coef_r[reg_idx] <= pwdata[COEF_BITS-1:0];
        end
        REG_FLUSH_THR: begin
          thr_r <= pwdata[THR_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // Read back, coefficients sign extended
  always_comb begin
    case (reg_idx_t'(reg_idx))
      REG_COEF_FF0, REG_COEF_FF1, REG_COEF_FF2, REG_COEF_FB1, REG_COEF_FB2: begin
        prdata = DATA_W'(coef_r[reg_idx]);
      end
      REG_FLUSH_THR: begin
        prdata = DATA_W'(thr_r);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign coef_o = coef_r;
  assign thr_o  = thr_r;

endmodule

// ===== src/bqd_mac.sv =====
// Shared multiply-accumulate unit of the biquad filter: one signed
// coefficient-by-state multiplier, a product register and a wide
// accumulator with round-half-up bias. Depends on bqd_pkg.
module bqd_mac #(
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqd_pkg::COEF_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bqd_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [COEF_BITS-1:0]          coef_i,
  input  logic signed [bqd_pkg::STATE_BITS-1:0] data_i,
  input  logic signed [SAMPLE_BITS-1:0]        x_i,
  output logic signed [bqd_pkg::Q_BITS-1:0]    q_o
);
  import bqd_pkg::*;

  localparam int COEF_FRAC = COEF_BITS - 4;
  localparam int PROD_W    = COEF_BITS + STATE_BITS;
  localparam int ACC_W     = PROD_W + 3;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pend_r;
  logic                     sub_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  x_scaled;
  logic signed [ACC_W-1:0]  prod_ext;

  assign x_scaled = ACC_W'(x_i) <<< COEF_FRAC;
  assign prod_ext = ACC_W'(prod_r);

  // Restart or fold in the pending product
  always_comb begin
    acc_nxt = acc_r;
    if (ctl_i.load) begin
      acc_nxt = (ctl_i.load_x ? x_scaled : '0) + HALF;
    end else if (pend_r) begin
      acc_nxt = sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  // Product pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= ctl_i.mul_en;
    end
  end

  // Product and accumulator payload
  always_ff @(posedge clk) begin
    if (ctl_i.mul_en) begin
      prod_r <= coef_i * data_i;
      sub_r  <= ctl_i.sub;
    end
    acc_r <= acc_nxt;
  end

  // Drop the fraction bits: floor after the half bias gives round half up
  assign q_o = acc_r[ACC_W-1:COEF_FRAC];

  a_load_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.load |-> !pend_r)
    else $error("accumulator restart collides with a pending product");

endmodule

// ===== src/bqd_ctrl.sv =====
// Sequencer of the biquad filter: channel delay words, the step schedule
// for the shared multiply-accumulate unit, saturation, flush and the
// output register. Depends on bqd_pkg, bqd_ifs.
module bqd_ctrl #(
  parameter int CHANNELS    = bqd_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqd_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  bqd_in_if.sink                                in_chan,
  bqd_out_if.source                             out_chan,
  input  logic signed [COEF_BITS-1:0]           coef_i [bqd_pkg::NUM_COEF],
  input  logic [bqd_pkg::THR_BITS-1:0]          thr_i,
  output bqd_pkg::mac_ctl_t                     mac_ctl_o,
  output logic signed [COEF_BITS-1:0]           mac_coef_o,
  output logic signed [bqd_pkg::STATE_BITS-1:0] mac_data_o,
  output logic signed [SAMPLE_BITS-1:0]         mac_x_o,
  input  logic signed [bqd_pkg::Q_BITS-1:0]     mac_q_i
);
  import bqd_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [STATE_BITS-1:0]  W_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0]  W_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  bqd_state_t state_r, state_nxt;

  // Delay words per channel
  logic signed [STATE_BITS-1:0] first_r  [CHANNELS];
  logic signed [STATE_BITS-1:0] second_r [CHANNELS];

  // Working copy of the transaction in flight
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          chan_r;
  logic                          bend_r;
  logic                          clr_r;
  logic [CH_W-1:0]               ch_r;
  logic signed [STATE_BITS-1:0]  w1_r;
  logic signed [STATE_BITS-1:0]  w2_r;
  logic signed [STATE_BITS-1:0]  w_r;
  logic                          clip_r;

  // Output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          chan_out_r;
  logic                          bend_out_r;
  logic                          sat_r;

  logic                          in_acc;
  logic                          emit;
  logic [CH_W-1:0]               ch_sel;
  logic                          w_ovf;
  logic signed [STATE_BITS-1:0]  w_sat;
  logic                          y_ovf;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [STATE_BITS:0]    w_ext;
  logic signed [STATE_BITS:0]    thr_ext;
  logic                          flush;

  assign in_acc = in_chan.valid && in_chan.ready;

  // Map an out-of-range channel onto the last one
  always_comb begin
    if (int'(in_chan.channel) < CHANNELS) begin
      ch_sel = CH_W'(in_chan.channel);
    end else begin
      ch_sel = CH_W'(CHANNELS - 1);
    end
  end

  // Clip the rounded sums
  assign w_ovf = !((&mac_q_i[Q_BITS-1:STATE_BITS-1]) || !(|mac_q_i[Q_BITS-1:STATE_BITS-1]));
  assign w_sat = w_ovf ? (mac_q_i[Q_BITS-1] ? W_MIN : W_MAX) : mac_q_i[STATE_BITS-1:0];
  assign y_ovf = !((&mac_q_i[Q_BITS-1:SAMPLE_BITS-1]) ||
                   !(|mac_q_i[Q_BITS-1:SAMPLE_BITS-1]));
  assign y_sat = y_ovf ? (mac_q_i[Q_BITS-1] ? Y_MIN : Y_MAX) : mac_q_i[SAMPLE_BITS-1:0];

  // Flush small magnitudes: -thr < w < thr
  assign w_ext   = (STATE_BITS+1)'(w_r);
  assign thr_ext = signed'((STATE_BITS+1)'(thr_i));
  assign flush   = (w_ext < thr_ext) && (w_ext > -thr_ext);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = in_chan.clear ? ST_EMIT : ST_FB1;
      ST_FB1:   state_nxt = ST_FB2;
      ST_FB2:   state_nxt = ST_FBW;
      ST_FBW:   state_nxt = ST_FBSAT;
      ST_FBSAT: state_nxt = ST_FF0;
      ST_FF0:   state_nxt = ST_FF1;
      ST_FF1:   state_nxt = ST_FF2;
      ST_FF2:   state_nxt = ST_FFW;
      ST_FFW:   state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: handshake and the multiply-accumulate schedule
  always_comb begin
    in_chan.ready = 1'b0;
    emit          = 1'b0;
    mac_ctl_o     = '0;
    mac_coef_o    = coef_i[REG_COEF_FB1];
    mac_data_o    = w1_r;
    case (state_r)
      ST_IDLE: begin
        // Hold off transactions while in reset
        in_chan.ready = rst_n;
      end
      ST_FB1: begin
        mac_ctl_o  = '{load: 1'b1, load_x: 1'b1, mul_en: 1'b1, sub: 1'b1};
        mac_coef_o = coef_i[REG_COEF_FB1];
        mac_data_o = w1_r;
      end
      ST_FB2: begin
        mac_ctl_o  = '{load: 1'b0, load_x: 1'b0, mul_en: 1'b1, sub: 1'b1};
        mac_coef_o = coef_i[REG_COEF_FB2];
        mac_data_o = w2_r;
      end
      ST_FF0: begin
        mac_ctl_o  = '{load: 1'b1, load_x: 1'b0, mul_en: 1'b1, sub: 1'b0};
        mac_coef_o = coef_i[REG_COEF_FF0];
        mac_data_o = w_r;
      end
      ST_FF1: begin
        mac_ctl_o  = '{load: 1'b0, load_x: 1'b0, mul_en: 1'b1, sub: 1'b0};
        mac_coef_o = coef_i[REG_COEF_FF1];
        mac_data_o = w1_r;
      end
      ST_FF2: begin
        mac_ctl_o  = '{load: 1'b0, load_x: 1'b0, mul_en: 1'b1, sub: 1'b0};
        mac_coef_o = coef_i[REG_COEF_FF2];
        mac_data_o = w2_r;
      end
      ST_EMIT: begin
        emit = !out_valid_r || out_chan.ready;
      end
      default: ;
    endcase
  end

  assign mac_x_o = x_r;

  // Control state, delay words and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        first_r[i]  <= '0;
        second_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end
      if (in_acc && in_chan.clear) begin
        for (int i = 0; i < CHANNELS; i++) begin
          first_r[i]  <= '0;
          second_r[i] <= '0;
        end
      end
      if (emit && !clr_r) begin
        second_r[ch_r] <= w1_r;
        first_r[ch_r]  <= flush ? '0 : w_r;
      end
    end
  end

  // Transaction payload and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= in_chan.sample_in;
      chan_r <= in_chan.channel;
      bend_r <= in_chan.block_end;
      clr_r  <= in_chan.clear;
      ch_r   <= ch_sel;
      w1_r   <= first_r[ch_sel];
      w2_r   <= second_r[ch_sel];
    end
    if (state_r == ST_FBSAT) begin
      w_r    <= w_sat;
      clip_r <= w_ovf;
    end
    if (emit) begin
      sample_r   <= clr_r ? '0 : y_sat;
      sat_r      <= !clr_r && (clip_r || y_ovf);
      chan_out_r <= chan_r;
      bend_out_r <= bend_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.sample_out    = sample_r;
  assign out_chan.channel_out   = chan_out_r;
  assign out_chan.block_end_out = bend_out_r;
  assign out_chan.saturated     = sat_r;

  a_sample_starts_feedback: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_chan.clear) |=> (state_r == ST_FB1))
    else $error("accepted sample did not start the feedback pass");

  a_clear_zeroes_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.clear) |=> (first_r[0] == '0 && second_r[CHANNELS-1] == '0))
    else $error("clear left delay state behind");

  a_emit_waits_for_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_chan.ready)
      |=> (state_r == ST_EMIT && out_valid_r))
    else $error("result overwrote an untaken output");

endmodule

// ===== src/biquad_iir_direct_form_two_top.sv =====
// Biquad IIR filter (Direct Form II), top level: configuration registers,
// sequencer and shared multiply-accumulate unit.
// Depends on bqd_pkg, bqd_ifs, bqd_cfg, bqd_mac, bqd_ctrl.
//
// Filters signed audio samples of up to CHANNELS channels through one
// second-order section: w = x - fb1*w1 - fb2*w2, y = ff0*w + ff1*w1 + ff2*w2,
// coefficients signed Q4.28 from the APB registers, each sum rounded half up,
// w saturated to 32 bits and y to the sample width. One result follows every
// transaction. A sample steps through the five products on one shared
// multiplier, each product registered before it is accumulated, plus the
// saturation and output steps; a clear transaction goes straight to the
// output step and zeroes the delays of every channel. in_chan.ready is
// low while a transaction is in progress and while a finished result waits
// for a full output register. Write coefficients only when the block is idle.
module biquad_iir_direct_form_two_top #(
  parameter int CHANNELS    = bqd_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqd_pkg::COEF_BITS_DEF,
  localparam int DATA_W     = (COEF_BITS > 32) ? 64 : 32,
  localparam int ADDR_W     = bqd_pkg::REG_IDX_BITS + ((DATA_W == 64) ? 3 : 2)
) (
  input  logic              clk,
  input  logic              rst_n,
  bqd_in_if.sink            in_chan,
  bqd_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);
  import bqd_pkg::*;

  logic signed [COEF_BITS-1:0]   coef   [NUM_COEF];
  logic [THR_BITS-1:0]           thr;
  mac_ctl_t                      mac_ctl;
  logic signed [COEF_BITS-1:0]   mac_coef;
  logic signed [STATE_BITS-1:0]  mac_data;
  logic signed [SAMPLE_BITS-1:0] mac_x;
  logic signed [Q_BITS-1:0]      mac_q;

  // Register file
  bqd_cfg #(
    .COEF_BITS (COEF_BITS),
    .DATA_W    (DATA_W),
    .ADDR_W    (ADDR_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef),
    .thr_o   (thr)
  );

  // Shared multiply-accumulate
  bqd_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (mac_ctl),
    .coef_i (mac_coef),
    .data_i (mac_data),
    .x_i    (mac_x),
    .q_o    (mac_q)
  );

  // Sequencer, delays and output register
  bqd_ctrl #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .coef_i     (coef),
    .thr_i      (thr),
    .mac_ctl_o  (mac_ctl),
    .mac_coef_o (mac_coef),
    .mac_data_o (mac_data),
    .mac_x_o    (mac_x),
    .mac_q_i    (mac_q)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for the biquad IIR filter top level: drives samples and APB writes,
// predicts each filtered result in a scoreboard class and checks it.
// Depends on bqd_pkg, the bqd_ifs channel interfaces and the filter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bqd_pkg::*;

  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int COEF_W   = COEF_BITS_DEF;
  localparam int FRAC     = COEF_W - 4;
  localparam int ADDR_W   = REG_IDX_BITS + 2;
  localparam int WIDE     = 80;

  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

  localparam logic [31:0] COEF_MIN = 32'h8000_0000;
  localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COEF_ONE = 32'h1000_0000;
  localparam real         COEF_SCALE = 268435456.0;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

  localparam logic signed [WIDE-1:0] ROUND_BIAS = 80'sd1 <<< (FRAC - 1);
  localparam logic signed [WIDE-1:0] STATE_HI = (80'sd1 <<< (STATE_BITS - 1)) - 80'sd1;
  localparam logic signed [WIDE-1:0] STATE_LO = -(80'sd1 <<< (STATE_BITS - 1));
  localparam logic signed [WIDE-1:0] SAMPLE_HI = (80'sd1 <<< (SAMPLE_W - 1)) - 80'sd1;
  localparam logic signed [WIDE-1:0] SAMPLE_LO = -(80'sd1 <<< (SAMPLE_W - 1));

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 190;

  typedef struct {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
    logic                       clear;
  } sample_txn_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
    logic                       block_end;
    logic                       saturated;
  } filtered_txn_t;

  // Tracks coefficients and per-channel delay words, predicts each output
  class filter_scoreboard;
    logic signed [COEF_W-1:0]     ff0, ff1, ff2, fb1, fb2;
    logic [THR_BITS-1:0]          flush_thr;
    logic signed [STATE_BITS-1:0] w1_store[CHANNELS_DEF];
    logic signed [STATE_BITS-1:0] w2_store[CHANNELS_DEF];
    filtered_txn_t                pending_outputs[$];
    int unsigned                  mismatches;

    function new();
      ff0 = COEF_ONE;
      ff1 = '0;
      ff2 = '0;
      fb1 = '0;
      fb2 = '0;
      flush_thr = 8'd1;
      foreach (w1_store[i]) begin
        w1_store[i] = '0;
        w2_store[i] = '0;
      end
      mismatches = 0;
    endfunction

    // Mirror a register write; unmapped indexes are dropped
    function void set_register(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
      case (idx)
        REG_COEF_FF0:  ff0 = value;
        REG_COEF_FF1:  ff1 = value;
        REG_COEF_FF2:  ff2 = value;
        REG_COEF_FB1:  fb1 = value;
        REG_COEF_FB2:  fb2 = value;
        REG_FLUSH_THR: flush_thr = value[THR_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Exact sum of products rounded half up to the state LSB
    function logic signed [WIDE-1:0] round_frac(logic signed [WIDE-1:0] acc);
      return (acc + ROUND_BIAS) >>> FRAC;
    endfunction

    // Run one section step for an accepted sample and queue its output
    function void note_sample(sample_txn_t t);
      logic signed [WIDE-1:0] x, w1, w2, w, y, acc, mag, thr;
      filtered_txn_t want;
      int c;
      want.channel   = t.channel;
      want.block_end = t.block_end;
      want.sample    = '0;
      want.saturated = 1'b0;
      if (t.clear) begin
        foreach (w1_store[i]) begin
          w1_store[i] = '0;
          w2_store[i] = '0;
        end
      end else begin
        c   = int'(t.channel);
        x   = t.sample;
        w1  = w1_store[c];
        w2  = w2_store[c];
        acc = (x <<< FRAC) - fb1 * w1 - fb2 * w2;
        w   = round_frac(acc);
        if (w > STATE_HI) begin
          w = STATE_HI;
          want.saturated = 1'b1;
        end else if (w < STATE_LO) begin
          w = STATE_LO;
          want.saturated = 1'b1;
        end
        acc = ff0 * w + ff1 * w1 + ff2 * w2;
        y   = round_frac(acc);
        if (y > SAMPLE_HI) begin
          y = SAMPLE_HI;
          want.saturated = 1'b1;
        end else if (y < SAMPLE_LO) begin
          y = SAMPLE_LO;
          want.saturated = 1'b1;
        end
        want.sample = y[SAMPLE_W-1:0];
        // Shift the delays, flushing tiny intermediates to zero
        mag = (w < 0) ? -w : w;
        thr = $signed({{(WIDE - THR_BITS){1'b0}}, flush_thr});
        w2_store[c] = w1_store[c];
        w1_store[c] = (mag < thr) ? '0 : w[STATE_BITS-1:0];
      end
      pending_outputs.push_back(want);
    endfunction

    // Compare an accepted output with the oldest prediction
    function void check_result(filtered_txn_t got);
      filtered_txn_t want;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: sample %0d channel %0d block_end %0d sat %0d",
                   got.sample, got.channel, got.block_end, got.saturated);
        return;
      end
      want = pending_outputs.pop_front();
      if (got.sample !== want.sample || got.channel !== want.channel ||
          got.block_end !== want.block_end || got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output mismatch: expected sample %0d ch %0d end %0d sat %0d, got %0d %0d %0d %0d",
                   want.sample, want.channel, want.block_end, want.saturated,
                   got.sample, got.channel, got.block_end, got.saturated);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  logic              pready;

  bqd_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  bqd_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_if ();

  biquad_iir_direct_form_two_top #(
    .CHANNELS    (CHANNELS_DEF),
    .SAMPLE_BITS (SAMPLE_W),
    .COEF_BITS   (COEF_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  filter_scoreboard sb = new();
  logic             steady = 1'b0;
  int unsigned      stall_left = 0;
  filtered_txn_t    seen_result;

  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic real unit_rand();
    return (real'(int'($urandom_range(0, 2000))) - 1000.0) / 1000.0;
  endfunction

  // Check each output transaction, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_result.sample    = out_if.sample_out;
      seen_result.channel   = out_if.channel_out;
      seen_result.block_end = out_if.block_end_out;
      seen_result.saturated = out_if.saturated;
      sb.check_result(seen_result);
    end
    if (!steady && stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left   <= steady ? 0 : pick_gap();
    end
  end

  // Offer one sample and hold it until the filter accepts it
  task automatic send_sample(logic ch, logic signed [SAMPLE_W-1:0] s, logic be, logic clr);
    int unsigned gap;
    sample_txn_t t;
    gap = steady ? 0 : pick_gap();
    t.channel   = ch;
    t.sample    = s;
    t.block_end = be;
    t.clear     = clr;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.channel   <= ch;
    in_if.sample_in <= s;
    in_if.block_end <= be;
    in_if.clear     <= clr;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(t);
  endtask

  // APB write: setup phase, access phase, then back to idle
  task automatic write_register(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_coefs(logic [31:0] ff0, logic [31:0] ff1, logic [31:0] ff2,
                             logic [31:0] fb1, logic [31:0] fb2, logic [31:0] thr);
    write_register(REG_COEF_FF0, ff0);
    write_register(REG_COEF_FF1, ff1);
    write_register(REG_COEF_FF2, ff2);
    write_register(REG_COEF_FB1, fb1);
    write_register(REG_COEF_FB2, fb2);
    write_register(REG_FLUSH_THR, thr);
  endtask

  // Stable poles from a random radius and angle, feedforward scaled by gain
  task automatic load_stable_filter(real gain, logic [31:0] thr);
    real r, theta;
    r     = 0.5 + 0.49 * (real'(int'($urandom_range(0, 1000))) / 1000.0);
    theta = 3.14159265 * (real'(int'($urandom_range(1, 999))) / 1000.0);
    write_coefs($rtoi(gain * unit_rand() * COEF_SCALE),
                $rtoi(gain * unit_rand() * COEF_SCALE),
                $rtoi(gain * unit_rand() * COEF_SCALE),
                $rtoi(-2.0 * r * $cos(theta) * COEF_SCALE),
                $rtoi(r * r * COEF_SCALE), thr);
  endtask

  // Drop valid and wait until every predicted output has been taken
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_sample();
    int unsigned pick;
    logic signed [SAMPLE_W-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      s = SAMPLE_W'($urandom);
    end else if (pick < 70) begin
      s = SAMPLE_W'($urandom_range(0, 600) - 300);
    end else if (pick < 80) begin
      case ($urandom_range(0, 4))
        0:       s = SMP_MAX;
        1:       s = SMP_MIN;
        2:       s = '0;
        3:       s = 24'sd1;
        default: s = -24'sd1;
      endcase
    end else begin
      s = SAMPLE_W'($urandom_range(0, 131071) - 65536);
    end
    send_sample(1'($urandom_range(0, 1)), s, $urandom_range(0, 7) == 0,
                $urandom_range(0, 29) == 0);
  endtask

  initial begin
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_if.valid     <= 1'b0;
    in_if.channel   <= 1'b0;
    in_if.sample_in <= '0;
    in_if.block_end <= 1'b0;
    in_if.clear     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pass-through at reset coefficients: sample extremes, clear
    send_sample(1'b0, SMP_MAX, 1'b0, 1'b0);
    send_sample(1'b1, SMP_MIN, 1'b1, 1'b0);
    send_sample(1'b0, 24'sd0, 1'b0, 1'b0);
    send_sample(1'b1, -24'sd1, 1'b0, 1'b0);
    send_sample(1'b0, 24'sd1, 1'b1, 1'b0);
    send_sample(1'b1, SAMPLE_W'($urandom), 1'b1, 1'b1);
    drain();

    // Extreme coefficients: state and output clipping, flushing at threshold 255
    write_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 32'd255);
    send_sample(1'b0, SMP_MAX, 1'b0, 1'b0);
    send_sample(1'b0, SMP_MIN, 1'b0, 1'b0);
    send_sample(1'b0, 24'sd100, 1'b0, 1'b0);
    send_sample(1'b0, -24'sd100, 1'b0, 1'b0);
    send_sample(1'b1, 24'sd200, 1'b0, 1'b0);
    send_sample(1'b1, -24'sd255, 1'b0, 1'b0);
    send_sample(1'b1, 24'sd255, 1'b0, 1'b0);
    send_sample(1'b0, SMP_MAX, 1'b0, 1'b0);
    send_sample(1'b0, SMP_MAX, 1'b0, 1'b0);
    send_sample(1'b1, 24'sd0, 1'b1, 1'b0);
    send_sample(1'b0, SMP_MIN, 1'b0, 1'b1);
    drain();

    // Zero threshold keeps single-LSB state; writes to unmapped indexes do nothing
    write_coefs(COEF_ONE, COEF_ONE, COEF_ONE, '0, '0, 32'd0);
    write_register(REG_SPARE_A, $urandom);
    write_register(REG_SPARE_B, $urandom);
    send_sample(1'b0, 24'sd1, 1'b0, 1'b0);
    send_sample(1'b0, -24'sd1, 1'b0, 1'b0);
    send_sample(1'b1, 24'sd0, 1'b0, 1'b0);
    send_sample(1'b0, 24'sd0, 1'b0, 1'b0);
    send_sample(1'b1, 24'sd1, 1'b0, 1'b0);
    send_sample(1'b0, 24'sd2, 1'b1, 1'b0);
    drain();

    // Random phases, each with its own coefficient set
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p == 4);
      case (p)
        0: load_stable_filter(1.0, $urandom_range(0, 8));
        1: write_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 32'd0);
        2: write_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 32'd255);
        4: load_stable_filter(7.0, 32'd255);
        5: write_coefs($urandom_range(0, 32'h2000_0000) - 32'h1000_0000,
                       $urandom_range(0, 32'h2000_0000) - 32'h1000_0000,
                       $urandom_range(0, 32'h2000_0000) - 32'h1000_0000,
                       $urandom_range(0, 32'h2000_0000) - 32'h1000_0000,
                       $urandom_range(0, 32'h2000_0000) - 32'h1000_0000, 32'd1);
        6: begin
          load_stable_filter(2.0, 32'd0);
          write_register(REG_SPARE_A, $urandom);
          write_register(REG_SPARE_B, $urandom);
        end
        default: write_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      repeat (PHASE_ITEMS) send_random_sample();
      drain();
    end

    steady = 1'b0;
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_outputs.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== biquad_iir_direct_form_two_top.f =====
src/bqd_pkg.sv
src/bqd_ifs.sv
src/bqd_cfg.sv
src/bqd_mac.sv
src/bqd_ctrl.sv
src/biquad_iir_direct_form_two_top.sv
dv/tb.sv
